// ===== sv/rzcd_pkg.sv =====
// Shared types and constants of the return-to-zero CSMA/CD transmitter.
`default_nettype none
package rzcd_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 64;
  localparam int unsigned CFG_W           = 20;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned RND_W           = 32;

  localparam logic [CFG_W-1:0] HALF_BIT_RESET = CFG_W'(497);
  localparam logic [CFG_W-1:0] BACKOFF_RESET  = CFG_W'(1000000);
  localparam logic [7:0]       START_SLOT     = 8'h80;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF  = 1'b1;

  // Function codes
  localparam logic [2:0] FUNC_LOAD      = 3'd0;
  localparam logic [2:0] FUNC_START     = 3'd1;
  localparam logic [2:0] FUNC_TICK      = 3'd2;
  localparam logic [2:0] FUNC_COLLISION = 3'd3;
  localparam logic [2:0] FUNC_IDLE      = 3'd4;
  localparam logic [2:0] FUNC_ABORT     = 3'd5;

  typedef struct packed {
    logic [2:0]       func;
    logic [5:0]       entry_index;
    logic [7:0]       byte_data;
    logic [7:0]       msg_length;
    logic             bus_idle;
    logic [RND_W-1:0] random_value;
  } in_item_t;

  typedef struct packed {
    logic       line_out;
    logic [1:0] tx_status;
    logic       accepted;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage
`default_nettype wire

// ===== sv/rzcd_in_if.sv =====
// Input channel of the transmitter: valid/ready with one command item.
`default_nettype none
interface rzcd_in_if;
  import rzcd_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface
`default_nettype wire

// ===== sv/rzcd_out_if.sv =====
// Result channel of the transmitter: valid/ready with one status item.
`default_nettype none
interface rzcd_out_if;
  import rzcd_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface
`default_nettype wire

// ===== sv/rz_csma_cd_transmitter.sv =====
// Return-to-zero serial line transmitter with CSMA/CD collision backoff.
// Usage: commands enter on in_i (load byte, start, tick, collision, bus idle,
// abort); every accepted command yields exactly one result on out_o carrying
// the line level, the transmitter status and the start acceptance flag.
// Configuration (half-bit ticks, backoff modulus) is written through
// cfg_we_i/cfg_idx_i/cfg_data_i while the block is idle.
// A result is registered and presented in the cycle after acceptance; commands
// go in at one per cycle unless stalled. A collision while sending with a
// non-zero modulus starts the 32-step remainder unit; in_i is not ready
// until it is done. Message characters sit in a registered-read RAM; a
// character fetch is issued by the command moving to it and lands next cycle.
// Reset: status done, line low, both configuration registers at their
// defaults; the message store holds no defined content until loaded.
// When out_o stalls, the result register holds and in_i deasserts ready
// until the pending result is taken.
`default_nettype none
module rz_csma_cd_transmitter #(
  parameter int unsigned STORE_DEPTH = rzcd_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [rzcd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [rzcd_pkg::CFG_W-1:0]       cfg_data_i,
  rzcd_in_if.sink                               in_i,
  rzcd_out_if.source                            out_o
);
  import rzcd_pkg::*;

  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  typedef enum logic [1:0] {
    TX_DONE    = 2'd0,
    TX_WAIT    = 2'd1,
    TX_SEND    = 2'd2,
    TX_HOLDOFF = 2'd3
  } tx_mode_e;

  tx_mode_e         mode_q, mode_d;
  logic [CFG_W-1:0] half_q, bmod_q;
  logic [7:0]       len_q, len_d;
  logic [7:0]       pos_q, pos_d;
  logic [7:0]       mask_q, mask_d;
  logic             dhalf_q, dhalf_d;
  logic [7:0]       char_q, char_d;
  logic [CFG_W-1:0] cnt_q, cnt_d;
  logic             line_q, line_d;
  logic             rdpend_q, rdpend_d;
  logic             ovalid_q, ovalid_d;
  out_item_t        oitem_q, oitem_d;

  logic             fire;
  logic             acc;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;
  logic [7:0]       char_cur;
  logic [7:0]       pos_inc;
  logic             div_start;
  mod_stat_t        div_stat;
  logic [CFG_W-1:0] div_rem;
  in_item_t         it;

  assign it         = in_i.item;
  assign in_i.ready = !div_stat.busy && !div_stat.done && (!ovalid_q || out_o.ready);
  assign fire       = in_i.valid && in_i.ready;
  assign char_cur   = rdpend_q ? ram_rdata : char_q;
  assign pos_inc    = pos_q + 8'd1;

  assign ram_we = fire && (it.func == FUNC_LOAD) && (mode_q == TX_DONE) &&
                  ({26'd0, it.entry_index} < 32'(STORE_DEPTH));

  assign div_start = fire && (it.func == FUNC_COLLISION) && (mode_q == TX_SEND) &&
                     (bmod_q != '0);

  always_comb begin
    mode_d    = mode_q;
    len_d     = len_q;
    pos_d     = pos_q;
    mask_d    = mask_q;
    dhalf_d   = dhalf_q;
    char_d    = char_cur;
    cnt_d     = cnt_q;
    line_d    = line_q;
    rdpend_d  = 1'b0;
    acc       = 1'b1;
    ram_re    = 1'b0;
    ram_raddr = '0;

    if (div_stat.done) begin
      cnt_d = div_rem;
    end

    if (fire) begin
      unique case (it.func)
        FUNC_LOAD: begin
        end
        FUNC_START: begin
          if (({1'b0, it.msg_length} > 9'(STORE_DEPTH)) || (mode_q != TX_DONE)) begin
            acc = 1'b0;
          end else if (it.msg_length != 8'd0) begin
            len_d = it.msg_length;
            pos_d = 8'd0;
            if (it.bus_idle) begin
              mode_d   = TX_SEND;
              cnt_d    = half_q;
              mask_d   = START_SLOT;
              dhalf_d  = 1'b1;
              ram_re   = 1'b1;
              rdpend_d = 1'b1;
            end else begin
              mode_d = TX_WAIT;
            end
          end
        end
        FUNC_TICK: begin
          if ((mode_q == TX_SEND) || (mode_q == TX_HOLDOFF)) begin
            if (cnt_q > CFG_W'(1)) begin
              cnt_d = cnt_q - 1'b1;
            end else begin
              cnt_d = '0;
              if (mode_q == TX_SEND) begin
                if (dhalf_q) begin
                  // data half: start slot is forced high
                  line_d  = (mask_q == START_SLOT) ? 1'b1 : |(char_cur & mask_q);
                  mask_d  = mask_q >> 1;
                  dhalf_d = 1'b0;
                  cnt_d   = half_q;
                end else begin
                  line_d  = 1'b0;
                  dhalf_d = 1'b1;
                  if (mask_q != 8'd0) begin
                    cnt_d = half_q;
                  end else if (pos_inc >= len_q) begin
                    mode_d = TX_DONE;
                    len_d  = 8'd0;
                    pos_d  = 8'd0;
                  end else begin
                    // advance to next character and fetch it
                    pos_d     = pos_inc;
                    mask_d    = START_SLOT;
                    cnt_d     = half_q;
                    ram_re    = 1'b1;
                    ram_raddr = pos_inc[AW-1:0];
                    rdpend_d  = 1'b1;
                  end
                end
              end else begin
                pos_d = 8'd0;
                if (it.bus_idle) begin
                  mode_d   = TX_SEND;
                  cnt_d    = half_q;
                  mask_d   = START_SLOT;
                  dhalf_d  = 1'b1;
                  ram_re   = 1'b1;
                  rdpend_d = 1'b1;
                end else begin
                  mode_d = TX_WAIT;
                end
              end
            end
          end
        end
        FUNC_COLLISION: begin
          if (mode_q == TX_SEND) begin
            line_d = 1'b0;
            mode_d = TX_HOLDOFF;
            // remainder unit loads the countdown when it finishes
            cnt_d  = '0;
          end
        end
        FUNC_IDLE: begin
          if (mode_q == TX_WAIT) begin
            pos_d    = 8'd0;
            mode_d   = TX_SEND;
            cnt_d    = half_q;
            mask_d   = START_SLOT;
            dhalf_d  = 1'b1;
            ram_re   = 1'b1;
            rdpend_d = 1'b1;
          end
        end
        FUNC_ABORT: begin
          mode_d = TX_DONE;
          len_d  = 8'd0;
          pos_d  = 8'd0;
          line_d = 1'b0;
        end
        default: begin
        end
      endcase
    end

    oitem_d.line_out  = line_d;
    oitem_d.tx_status = mode_d;
    oitem_d.accepted  = acc;
    if (fire) begin
      ovalid_d = 1'b1;
    end else if (out_o.ready) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q   <= HALF_BIT_RESET;
      bmod_q   <= BACKOFF_RESET;
      mode_q   <= TX_DONE;
      len_q    <= 8'd0;
      pos_q    <= 8'd0;
      mask_q   <= 8'd0;
      dhalf_q  <= 1'b1;
      char_q   <= 8'd0;
      cnt_q    <= '0;
      line_q   <= 1'b0;
      rdpend_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_HALF_BIT: half_q <= cfg_data_i;
          CFG_BACKOFF:  bmod_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      mode_q   <= mode_d;
      len_q    <= len_d;
      pos_q    <= pos_d;
      mask_q   <= mask_d;
      dhalf_q  <= dhalf_d;
      char_q   <= char_d;
      cnt_q    <= cnt_d;
      line_q   <= line_d;
      rdpend_q <= rdpend_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      oitem_q <= oitem_d;
    end
  end

  assign out_o.valid = ovalid_q;
  assign out_o.item  = oitem_q;

  rzcd_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(it.entry_index)),
    .wdata_i (it.byte_data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rzcd_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (it.random_value),
    .divisor_i  (bmod_q),
    .stat_o     (div_stat),
    .rem_o      (div_rem)
  );

  a_done_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == TX_DONE) |-> (len_q == 8'd0))
    else $error("length left over while done");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != TX_DONE) |-> (pos_q < len_q))
    else $error("character position beyond message length");

  a_line_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q |-> (mode_q == TX_SEND))
    else $error("line high outside of sending");

  a_rem_backoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (mode_q == TX_HOLDOFF))
    else $error("backoff remainder finished outside of backoff");

endmodule
`default_nettype wire

// ===== sv/rzcd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module rzcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== sv/rzcd_mod.sv =====
// Bit-serial remainder unit: reduces the random value modulo the backoff modulus.
`default_nettype none
module rzcd_mod (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [rzcd_pkg::RND_W-1:0]    dividend_i,
  input  wire logic [rzcd_pkg::CFG_W-1:0]    divisor_i,
  output rzcd_pkg::mod_stat_t                stat_o,
  output logic      [rzcd_pkg::CFG_W-1:0]    rem_o
);
  import rzcd_pkg::*;

  localparam int unsigned CNT_W = $clog2(RND_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [RND_W-1:0] dvd_q, dvd_d;
  logic [CFG_W-1:0] dvs_q, dvs_d;
  logic [CFG_W-1:0] rem_q, rem_d;
  logic             done_q, done_d;
  logic [CFG_W:0]   shifted;

  always_comb begin
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    done_d  = 1'b0;
    shifted = {rem_q, dvd_q[RND_W-1]};
    if (start_i) begin
      cnt_d = CNT_W'(RND_W);
      dvd_d = dividend_i;
      dvs_d = divisor_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      // one quotient bit a cycle: shift in, subtract when it fits
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = CFG_W'(shifted - {1'b0, dvs_q});
      end else begin
        rem_d = CFG_W'(shifted);
      end
      dvd_d  = {dvd_q[RND_W-2:0], 1'b0};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule
`default_nettype wire

// ===== bench/rz_csma_cd_transmitter_tb.sv =====
// Self-checking testbench of the return-to-zero CSMA/CD transmitter.
`default_nettype none
module rz_csma_cd_transmitter_tb;
  import rzcd_pkg::*;

  localparam int unsigned MSG_DEPTH   = STORE_DEPTH_DEF;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam logic [2:0]  FUNC_RSVD6  = 3'd6;
  localparam logic [2:0]  FUNC_RSVD7  = 3'd7;

  typedef enum logic [1:0] {
    TX_DONE    = 2'd0,
    TX_WAIT    = 2'd1,
    TX_SEND    = 2'd2,
    TX_HOLDOFF = 2'd3
  } xmit_state_e;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  rzcd_in_if  cmd_if ();
  rzcd_out_if status_if ();

  rz_csma_cd_transmitter DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (cmd_if),
    .out_o      (status_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Transmitter state as the predictor sees it
  logic [CFG_W-1:0] half_ticks  = HALF_BIT_RESET;
  logic [CFG_W-1:0] backoff_mod = BACKOFF_RESET;
  xmit_state_e      xmit_state  = TX_DONE;
  logic [7:0]       store_bytes [MSG_DEPTH];
  bit               store_loaded [MSG_DEPTH];
  logic [7:0]       msg_len       = '0;
  logic [7:0]       char_pos      = '0;
  logic [7:0]       slot_mask     = '0;
  logic             data_half_due = 1'b1;
  logic [7:0]       cur_char      = '0;
  logic [CFG_W-1:0] ticks_left    = '0;
  logic             line_lvl      = 1'b0;

  out_item_t   pending_status [$];
  int unsigned err_count       = 0;
  int unsigned items_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned msgs_done       = 0;
  int unsigned collisions      = 0;
  int unsigned settings_used   = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned hold_left       = 0;
  bit          jitter_on       = 1'b1;

  function automatic void fetch_char();
    slot_mask     = START_SLOT;
    data_half_due = 1'b1;
    cur_char      = store_bytes[char_pos];
  endfunction

  function automatic void begin_message();
    char_pos   = '0;
    fetch_char();
    xmit_state = TX_SEND;
    ticks_left = half_ticks;
  endfunction

  function automatic void half_period_end();
    if (data_half_due) begin
      line_lvl      = (slot_mask == START_SLOT) ? 1'b1 : |(cur_char & slot_mask);
      slot_mask     = slot_mask >> 1;
      data_half_due = 1'b0;
      ticks_left    = half_ticks;
    end else begin
      line_lvl      = 1'b0;
      data_half_due = 1'b1;
      if (slot_mask != '0) begin
        ticks_left = half_ticks;
      end else begin
        char_pos = char_pos + 8'd1;
        if (char_pos >= msg_len) begin
          xmit_state = TX_DONE;
          msg_len    = '0;
          char_pos   = '0;
          msgs_done++;
        end else begin
          fetch_char();
          ticks_left = half_ticks;
        end
      end
    end
  endfunction

  function automatic void advance_tick(logic idle);
    if (xmit_state != TX_SEND && xmit_state != TX_HOLDOFF) return;
    if (ticks_left > 20'd1) begin
      ticks_left = ticks_left - 20'd1;
      return;
    end
    ticks_left = '0;
    if (xmit_state == TX_SEND) begin
      half_period_end();
    end else begin
      char_pos = '0;
      if (idle) begin_message();
      else xmit_state = TX_WAIT;
    end
  endfunction

  function automatic out_item_t predict_status(in_item_t c);
    out_item_t r;
    r.accepted = 1'b1;
    case (c.func)
      FUNC_LOAD: begin
        if (xmit_state == TX_DONE) begin
          store_bytes[c.entry_index]  = c.byte_data;
          store_loaded[c.entry_index] = 1'b1;
        end
      end
      FUNC_START: begin
        if (c.msg_length > MSG_DEPTH || xmit_state != TX_DONE) begin
          r.accepted = 1'b0;
        end else if (c.msg_length != '0) begin
          msg_len  = c.msg_length;
          char_pos = '0;
          if (c.bus_idle) begin_message();
          else xmit_state = TX_WAIT;
        end
      end
      FUNC_TICK: advance_tick(c.bus_idle);
      FUNC_COLLISION: begin
        if (xmit_state == TX_SEND) begin
          line_lvl   = 1'b0;
          ticks_left = (backoff_mod != '0) ? CFG_W'(c.random_value % 32'(backoff_mod)) : '0;
          xmit_state = TX_HOLDOFF;
          collisions++;
        end
      end
      FUNC_IDLE: if (xmit_state == TX_WAIT) begin_message();
      FUNC_ABORT: begin
        xmit_state = TX_DONE;
        msg_len    = '0;
        char_pos   = '0;
        line_lvl   = 1'b0;
      end
      default: ;
    endcase
    r.line_out  = line_lvl;
    r.tx_status = xmit_state;
    return r;
  endfunction

  function automatic bit prefix_loaded(int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      if (!store_loaded[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic in_item_t rand_cmd(logic [2:0] f);
    in_item_t c;
    c.func         = f;
    c.entry_index  = 6'($urandom);
    c.byte_data    = 8'($urandom);
    c.msg_length   = 8'($urandom);
    c.bus_idle     = 1'($urandom);
    c.random_value = $urandom;
    return c;
  endfunction

  function automatic in_item_t make_cmd(logic [2:0] f, logic [5:0] idx, logic [7:0] data,
                                        logic [7:0] len, logic idle, logic [31:0] rnd);
    in_item_t c;
    c.func         = f;
    c.entry_index  = idx;
    c.byte_data    = data;
    c.msg_length   = len;
    c.bus_idle     = idle;
    c.random_value = rnd;
    return c;
  endfunction

  function automatic logic [2:0] noise_func();
    case ($urandom_range(0, 5))
      0:       return FUNC_TICK;
      1:       return FUNC_COLLISION;
      2:       return FUNC_IDLE;
      3:       return FUNC_RSVD6;
      4:       return FUNC_RSVD7;
      default: return FUNC_LOAD;
    endcase
  endfunction

  // Offer one command, wait for the transaction, record the predicted status
  task automatic issue(in_item_t c);
    if (jitter_on && $urandom_range(0, 5) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.item  <= c;
    do @(posedge clk); while (!cmd_if.ready);
    pending_status.push_back(predict_status(c));
    items_sent++;
  endtask

  // Stop offering and let every outstanding result and backoff remainder drain
  task automatic settle();
    cmd_if.valid <= 1'b0;
    while (pending_status.size() != 0 || !cmd_if.ready) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_timing(logic [CFG_W-1:0] half, logic [CFG_W-1:0] modulus);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_HALF_BIT;
    cfg_data <= half;
    @(posedge clk);
    cfg_idx  <= CFG_BACKOFF;
    cfg_data <= modulus;
    @(posedge clk);
    cfg_we      <= 1'b0;
    half_ticks  = half;
    backoff_mod = modulus;
    settings_used++;
  endtask

  task automatic send_message(int unsigned len);
    in_item_t c;
    for (int unsigned i = 0; i < len; i++) begin
      c             = rand_cmd(FUNC_LOAD);
      c.entry_index = 6'(i);
      issue(c);
    end
    c            = rand_cmd(FUNC_START);
    c.msg_length = 8'(len);
    issue(c);
  endtask

  task automatic traffic_step();
    in_item_t    c;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (xmit_state)
      TX_DONE: begin
        if (roll < 55) begin
          send_message(($urandom_range(0, 7) == 0) ? $urandom_range(5, 16)
                                                     : $urandom_range(1, 4));
        end else if (roll < 65) begin
          issue(rand_cmd(FUNC_LOAD));
        end else if (roll < 75) begin
          // keep accepted starts within what has been loaded
          c = rand_cmd(FUNC_START);
          if (c.msg_length <= MSG_DEPTH && !prefix_loaded(c.msg_length)) c.msg_length = '0;
          issue(c);
        end else if (roll < 92) begin
          issue(rand_cmd(noise_func()));
        end else begin
          issue(rand_cmd(FUNC_ABORT));
        end
      end
      TX_WAIT: begin
        if (roll < 70) issue(rand_cmd(FUNC_IDLE));
        else if (roll < 80) issue(rand_cmd(FUNC_TICK));
        else if (roll < 88) issue(rand_cmd(noise_func()));
        else if (roll < 95) issue(rand_cmd(FUNC_START));
        else issue(rand_cmd(FUNC_ABORT));
      end
      TX_SEND: begin
        if (roll < 90) issue(rand_cmd(FUNC_TICK));
        else if (roll < 92) issue(rand_cmd(FUNC_COLLISION));
        else if (roll < 93) issue(rand_cmd(FUNC_ABORT));
        else if (roll < 96) issue(rand_cmd(FUNC_START));
        else issue(rand_cmd(noise_func()));
      end
      default: begin
        if (roll < 88) issue(rand_cmd(FUNC_TICK));
        else if (roll < 91) issue(rand_cmd(FUNC_IDLE));
        else if (roll < 93) issue(rand_cmd(FUNC_COLLISION));
        else if (roll < 95) issue(rand_cmd(FUNC_ABORT));
        else issue(rand_cmd(noise_func()));
      end
    endcase
  endtask

  task automatic run_traffic(int unsigned n);
    int unsigned goal;
    goal = items_sent + n;
    while (items_sent < goal) traffic_step();
  endtask

  // Every command and corner case, under the reset timing
  task automatic test_directed_cases();
    issue(make_cmd(FUNC_LOAD, 6'd0, 8'h00, 8'd0, 1'b0, 32'd0));
    issue(make_cmd(FUNC_LOAD, 6'd63, 8'hFF, 8'd255, 1'b1, 32'hFFFF_FFFF));
    issue(make_cmd(FUNC_LOAD, 6'd1, 8'hA5, 8'd3, 1'b0, 32'd7));
    issue(make_cmd(FUNC_START, 6'd0, 8'h00, 8'd255, 1'b1, 32'd0));
    issue(make_cmd(FUNC_START, 6'd0, 8'h00, 8'd65, 1'b1, 32'd0));
    issue(make_cmd(FUNC_START, 6'd0, 8'h00, 8'd0, 1'b1, 32'd0));
    issue(make_cmd(FUNC_TICK, 6'd63, 8'hFF, 8'd2, 1'b1, 32'd0));
    issue(make_cmd(FUNC_COLLISION, 6'd0, 8'h00, 8'd2, 1'b1, 32'hFFFF_FFFF));
    issue(make_cmd(FUNC_IDLE, 6'd0, 8'h00, 8'd2, 1'b1, 32'd0));
    issue(make_cmd(FUNC_RSVD6, 6'd63, 8'hFF, 8'd255, 1'b1, 32'hFFFF_FFFF));
    issue(make_cmd(FUNC_RSVD7, 6'd0, 8'h00, 8'd0, 1'b0, 32'd0));
    issue(make_cmd(FUNC_START, 6'd0, 8'h00, 8'd2, 1'b0, 32'd0));
    issue(make_cmd(FUNC_LOAD, 6'd2, 8'h5A, 8'd0, 1'b0, 32'd0));
    issue(make_cmd(FUNC_TICK, 6'd0, 8'h00, 8'd0, 1'b1, 32'd0));
    issue(make_cmd(FUNC_COLLISION, 6'd0, 8'h00, 8'd0, 1'b0, 32'd5));
    issue(make_cmd(FUNC_START, 6'd0, 8'h00, 8'd1, 1'b1, 32'd0));
    issue(make_cmd(FUNC_IDLE, 6'd0, 8'h00, 8'd0, 1'b1, 32'd0));
    issue(make_cmd(FUNC_TICK, 6'd0, 8'h00, 8'd0, 1'b0, 32'd0));
    // a backoff of zero expires on the next tick; a busy bus then parks it
    issue(make_cmd(FUNC_COLLISION, 6'd0, 8'h00, 8'd0, 1'b0, 32'd0));
    issue(make_cmd(FUNC_IDLE, 6'd0, 8'h00, 8'd0, 1'b1, 32'd0));
    issue(make_cmd(FUNC_TICK, 6'd0, 8'h00, 8'd0, 1'b0, 32'd0));
    issue(make_cmd(FUNC_IDLE, 6'd0, 8'h00, 8'd0, 1'b1, 32'd0));
    issue(make_cmd(FUNC_COLLISION, 6'd0, 8'h00, 8'd0, 1'b1, 32'hFFFF_FFFF));
    issue(make_cmd(FUNC_ABORT, 6'd63, 8'hFF, 8'd255, 1'b1, 32'hFFFF_FFFF));
    settle();
  endtask

  // Fill the whole store and send the longest message at the fastest timing
  task automatic test_full_store();
    in_item_t c;
    set_timing(CFG_W'(1), CFG_W'(1));
    for (int unsigned i = 0; i < MSG_DEPTH; i++) begin
      c             = rand_cmd(FUNC_LOAD);
      c.entry_index = 6'(i);
      issue(c);
    end
    c            = rand_cmd(FUNC_START);
    c.msg_length = 8'(MSG_DEPTH);
    c.bus_idle   = 1'b1;
    issue(c);
    repeat (40) issue(rand_cmd(FUNC_TICK));
    issue(rand_cmd(FUNC_COLLISION));
    c          = rand_cmd(FUNC_TICK);
    c.bus_idle = 1'b1;
    issue(c);
    repeat (20) issue(rand_cmd(FUNC_TICK));
    issue(rand_cmd(FUNC_ABORT));
    settle();
  endtask

  task automatic test_extreme_timing();
    set_timing('1, '1);
    issue(make_cmd(FUNC_START, 6'd0, 8'h00, 8'd1, 1'b1, 32'd0));
    repeat (5) issue(rand_cmd(FUNC_TICK));
    issue(make_cmd(FUNC_COLLISION, 6'd0, 8'h00, 8'd0, 1'b1, 32'hFFFF_FFFF));
    repeat (3) issue(rand_cmd(FUNC_TICK));
    issue(rand_cmd(FUNC_ABORT));
    issue(make_cmd(FUNC_START, 6'd0, 8'h00, 8'd2, 1'b0, 32'd0));
    issue(make_cmd(FUNC_IDLE, 6'd0, 8'h00, 8'd0, 1'b0, 32'd0));
    issue(rand_cmd(FUNC_TICK));
    issue(make_cmd(FUNC_COLLISION, 6'd0, 8'h00, 8'd0, 1'b0, 32'h000F_FFFE));
    issue(rand_cmd(FUNC_TICK));
    issue(rand_cmd(FUNC_ABORT));
    settle();
  endtask

  // Hold the result side off while commands keep coming, then pause the sender
  task automatic test_backpressure();
    set_timing(CFG_W'(2), CFG_W'(9));
    hold_left = 60;
    run_traffic(30);
    settle();
    run_traffic(30);
    settle();
  endtask

  task automatic test_random_phases();
    for (int unsigned p = 0; p < 3; p++) begin
      set_timing(CFG_W'($urandom_range(1, 3)), CFG_W'($urandom_range(1, 40)));
      run_traffic(140);
      settle();
    end
  endtask

  task automatic test_quiet_finish();
    jitter_on = 1'b0;
    set_timing(CFG_W'(3), CFG_W'(4));
    run_traffic(120);
    settle();
  endtask

  initial begin : result_sink
    int unsigned burst;
    burst = 0;
    status_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        status_if.ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        status_if.ready <= 1'b0;
      end else if (jitter_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 3);
        status_if.ready <= 1'b0;
      end else begin
        status_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if ((cmd_if.valid && cmd_if.ready) || (status_if.valid && status_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (status_if.valid && status_if.ready) begin
        if (pending_status.size() == 0) begin
          $error("status transaction with no command pending");
          err_count++;
        end else begin
          want = pending_status.pop_front();
          results_checked++;
          if (status_if.item.line_out !== want.line_out) begin
            $error("line_out: expected %0d, got %0d", want.line_out, status_if.item.line_out);
            err_count++;
          end
          if (status_if.item.tx_status !== want.tx_status) begin
            $error("tx_status: expected %0d, got %0d", want.tx_status,
                   status_if.item.tx_status);
            err_count++;
          end
          if (status_if.item.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, status_if.item.accepted);
            err_count++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_n        <= 1'b0;
    cmd_if.valid <= 1'b0;
    cmd_if.item  <= '0;
    cfg_we       <= 1'b0;
    cfg_idx      <= CFG_HALF_BIT;
    cfg_data     <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_full_store();
    test_extreme_timing();
    test_backpressure();
    test_random_phases();
    test_quiet_finish();
    $display("covered %0d commands and %0d status results over %0d timing settings",
             items_sent, results_checked, settings_used);
    $display("  %0d messages sent to the end, %0d collisions backed off", msgs_done, collisions);
    if (err_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
